>>> rtl/core/idwl_pkg.sv
package idwl_pkg;

    localparam int ID_W    = 23;
    localparam int COUNT_W = 8;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]      operation;
        logic [ID_W-1:0] id_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

>>> rtl/core/id_whitelist_set_table.sv
// Set table of distinct nonzero identifiers, filled in order. A command is
// taken when start is high and busy is low; its one result appears on result
// with done high for exactly one cycle, and the receiver cannot stall it.
// Add and lookup walk the valid entries through the entry memory, one entry
// per cycle with a registered read; an invalid add, a clear or the unused
// code skips the walk. A new command may start in the cycle its
// predecessor's result is shown. max_id is written over cfg_data; the user
// must write it only while the block is idle, which the block itself does
// not enforce. cfg_ready is always high.
module id_whitelist_set_table #(
    parameter int ENTRIES = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  idwl_pkg::cmd_t                cmd,
    output logic                          done,
    output idwl_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [idwl_pkg::ID_W-1:0]     cfg_data
);
    import idwl_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [ID_W-1:0] MAX_ID_RESET = 23'd4194304;

    state_t          state_reg, state_next;
    logic [1:0]      op_reg;
    logic [ID_W-1:0] id_reg;
    logic            inv_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   issue_reg, issue_next;
    logic            pend_reg, pend_next;
    logic            hit_reg, hit_next;
    logic            done_reg;
    result_t         result_reg, result_next;
    logic [ID_W-1:0] max_id_reg;

    logic [ID_W-1:0] mem [ENTRIES];
    logic [ID_W-1:0] rd_data_reg;
    logic            rd_en;
    logic            wr_en;
    logic            accept;
    logic            match;
    logic            scan_end;
    logic            full;
    logic            add_bad;
    logic [CW+COUNT_W-1:0] count_ext;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    assign add_bad  = (cmd.id_value == '0) || (cmd.id_value > max_id_reg);
    assign match    = pend_reg && (rd_data_reg == id_reg);
    assign scan_end = match || (issue_reg == count_reg);
    assign full     = (count_reg >= CW'(ENTRIES));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd.operation == OP_LOOKUP) ||
                        ((cmd.operation == OP_ADD) && !add_bad))
                        state_next = S_SCAN;
                    else
                        state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (scan_end)
                    state_next = S_FINISH;
            end
            S_FINISH:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Scan control, result and count update
    always_comb
    begin
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        issue_next  = issue_reg;
        pend_next   = 1'b0;
        hit_next    = hit_reg;
        count_next  = count_reg;
        result_next = result_reg;
        count_ext   = '0;
        case (state_reg)
            S_IDLE:
            begin
                issue_next = '0;
                hit_next   = 1'b0;
            end
            S_SCAN:
            begin
                hit_next = hit_reg | match;
                if (!scan_end)
                begin
                    rd_en      = 1'b1;
                    pend_next  = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                result_next.status = ST_OK;
                result_next.found  = 1'b0;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (inv_reg)
                            result_next.status = ST_INVALID;
                        else if (hit_reg)
                            result_next.status = ST_PRESENT;
                        else if (full)
                            result_next.status = ST_FULL;
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    OP_LOOKUP:
                        result_next.found = hit_reg;
                    OP_CLEAR:
                        count_next = '0;
                    default:
                        count_next = count_reg;
                endcase
                count_ext = {{COUNT_W{1'b0}}, count_next};
                result_next.entry_count = count_ext[COUNT_W-1:0];
            end
            default:
                issue_next = '0;
        endcase
    end

    // Entry memory: one read and one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[issue_reg[AW-1:0]];
        if (wr_en)
            mem[count_reg[AW-1:0]] <= id_reg;
    end

    // Hold the command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.operation;
            id_reg  <= cmd.id_value;
            inv_reg <= add_bad;
        end
        result_reg <= result_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            issue_reg  <= '0;
            pend_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            done_reg   <= 1'b0;
            max_id_reg <= MAX_ID_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            done_reg  <= (state_reg == S_FINISH);
            if (cfg_valid && cfg_ready)
                max_id_reg <= cfg_data;
        end
    end

`ifndef SYNTHESIS
    // A result beat follows only the finishing cycle
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FINISH))
        else $error("result beat without a finished command");

    // Fill count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("entry count above capacity");

    // Reads never reach past the valid entries
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (issue_reg < count_reg))
        else $error("read beyond valid entries");

    // An accepted command keeps the block busy in the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");
`endif

endmodule
